>>> sv/rars_pkg.sv
// shared types and constants for the range add / range sum block
package rars_pkg;
  localparam int unsigned MaxElementsDef = 1024;
  localparam int unsigned IdxW = 11;
  localparam int unsigned ValW = 32;
  localparam int unsigned AccW = 64;

  typedef enum logic [0:0] {
    REQ_ADD   = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADD_RD,
    ST_ADD_WAIT,
    ST_ADD_WR,
    ST_Q_RD,
    ST_Q_WAIT,
    ST_Q_ACC,
    ST_Q_MUL,
    ST_Q_FIN,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic add_init;   // start an update walk, pass select in dp
    logic add_step;   // write node and advance
    logic rd;         // issue memory read
    logic q_init;     // start a prefix walk
    logic q_acc;      // accumulate read data and advance
    logic q_mul;      // form k*B
    logic q_fin;      // fold prefix into result
    logic out_load;   // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;        // request range invalid
    logic is_query;
    logic walk_done;  // current walk position out of range / zero
    logic last_pass;  // current pass is the final one
  } stat_t;
endpackage

>>> sv/rars_if.sv
// valid/ready channel interfaces
interface rars_req_if;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [10:0]             left_index;
  logic [10:0]             right_index;
  logic signed [31:0]      add_value;
  modport source (output valid, req_type, left_index, right_index, add_value, input ready);
  modport sink (input valid, req_type, left_index, right_index, add_value, output ready);
endinterface

interface rars_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] range_sum;
  logic               bad_range;
  modport source (output valid, range_sum, bad_range, input ready);
  modport sink (input valid, range_sum, bad_range, output ready);
endinterface

interface rars_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] size_in_use;
  modport source (output valid, size_in_use, input ready);
  modport sink (input valid, size_in_use, output ready);
endinterface

>>> sv/rars_ctrl.sv
// sequencer for update and prefix walks
module rars_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output rars_pkg::cmd_t  cmd_o,
  input  rars_pkg::stat_t stat_i
);
  import rars_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.bad) state_d = ST_OUT;
        else if (stat_i.is_query) state_d = ST_Q_RD;
        else state_d = ST_ADD_RD;
      end
      ST_ADD_RD: begin
        if (stat_i.walk_done) state_d = stat_i.last_pass ? ST_IDLE : ST_ADD_RD;
        else state_d = ST_ADD_WAIT;
      end
      ST_ADD_WAIT: state_d = ST_ADD_WR;
      ST_ADD_WR: state_d = ST_ADD_RD;
      ST_Q_RD: begin
        if (stat_i.walk_done) state_d = ST_Q_MUL;
        else state_d = ST_Q_WAIT;
      end
      ST_Q_WAIT: state_d = ST_Q_ACC;
      ST_Q_ACC: state_d = ST_Q_RD;
      ST_Q_MUL: state_d = ST_Q_FIN;
      ST_Q_FIN: state_d = stat_i.last_pass ? ST_OUT : ST_Q_RD;
      ST_OUT: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load = req_valid_i;
      end
      ST_CHECK: begin
        cmd_o.add_init = !stat_i.bad && !stat_i.is_query;
        cmd_o.q_init = !stat_i.bad && stat_i.is_query;
        cmd_o.out_load = stat_i.bad;
      end
      ST_ADD_RD: begin
        cmd_o.rd = !stat_i.walk_done;
        cmd_o.add_init = stat_i.walk_done && !stat_i.last_pass;
      end
      ST_ADD_WR: cmd_o.add_step = 1'b1;
      ST_Q_RD: cmd_o.rd = !stat_i.walk_done;
      ST_Q_ACC: cmd_o.q_acc = 1'b1;
      ST_Q_MUL: cmd_o.q_mul = 1'b1;
      ST_Q_FIN: begin
        cmd_o.q_fin = 1'b1;
        cmd_o.out_load = stat_i.last_pass;
      end
      ST_OUT: rsp_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

>>> sv/rars_dp.sv
// tree memories, walk position and accumulators
module rars_dp #(
  parameter int unsigned MaxElements = rars_pkg::MaxElementsDef,
  parameter int unsigned AddrW = $clog2(MaxElements + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clr_busy_i,
  output logic                   clr_done_o,
  input  logic [10:0]            size_i,
  input  logic                   req_type_i,
  input  logic [10:0]            left_i,
  input  logic [10:0]            right_i,
  input  logic signed [31:0]     value_i,
  input  rars_pkg::cmd_t         cmd_i,
  output rars_pkg::stat_t        stat_o,
  output logic signed [63:0]     sum_o,
  output logic                   bad_o
);
  import rars_pkg::*;

  localparam int unsigned Depth = MaxElements + 1;
  localparam int unsigned PosW = AddrW + 1;

  logic [AccW-1:0] diff_mem [Depth];
  logic [AccW-1:0] wgt_mem [Depth];

  logic            qry_q;
  logic [10:0]     l_q, r_q;
  logic [AccW-1:0] v_q;
  logic            bad_q;
  logic [1:0]      pass_q;
  logic [PosW-1:0] pos_q;
  logic [AccW-1:0] dinc_q, winc_q;
  logic [AccW-1:0] drd_q, wrd_q;
  logic [AccW-1:0] bacc_q, cacc_q, kb_q, res_q;
  logic [10:0]     k_q;
  logic [AccW-1:0] sum_q;
  logic            obad_q;
  logic [AddrW-1:0] clr_q;

  logic [PosW-1:0] low;
  logic [PosW-1:0] sz;
  logic [AddrW-1:0] addr;

  assign sz = (32'(size_i) > MaxElements) ? PosW'(MaxElements) : PosW'(size_i);
  assign low = pos_q & (~pos_q + PosW'(1));
  assign addr = pos_q[AddrW-1:0];

  // add: pass 0 at left, pass 1 at right+1
  // query: pass 0 prefix(right), pass 1 prefix(left-1)

  always_comb begin
    stat_o.bad = bad_q;
    stat_o.is_query = qry_q;
    stat_o.walk_done = (pos_q == '0) || (pos_q > sz);
    stat_o.last_pass = qry_q ? (pass_q == 2'd1) : (pass_q == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      clr_done_o <= 1'b0;
    end else if (clr_busy_i && !clr_done_o) begin
      clr_q <= clr_q + AddrW'(1);
      if (clr_q == AddrW'(Depth - 1)) clr_done_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!clr_done_o) begin
      diff_mem[clr_q] <= '0;
      wgt_mem[clr_q] <= '0;
    end else if (cmd_i.add_step) begin
      diff_mem[addr] <= drd_q + dinc_q;
      wgt_mem[addr] <= wrd_q + winc_q;
    end
    if (cmd_i.rd) begin
      drd_q <= diff_mem[addr];
      wrd_q <= wgt_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qry_q <= req_type_i;
      l_q <= left_i;
      r_q <= right_i;
      v_q <= AccW'(value_i);
      bad_q <= (left_i == 11'd0) || (left_i > right_i) || (right_i > size_i);
      pass_q <= 2'd0;
    end
    if (cmd_i.add_init) begin
      pass_q <= pass_q + 2'd1;
      if (pass_q == 2'd0) begin
        pos_q <= PosW'(l_q);
        dinc_q <= v_q;
        winc_q <= v_q * AccW'(l_q - 11'd1);
      end else begin
        pos_q <= PosW'(r_q) + PosW'(1);
        dinc_q <= AccW'(0) - v_q;
        winc_q <= AccW'(0) - v_q * AccW'(r_q);
      end
    end
    if (cmd_i.add_step) pos_q <= pos_q + low;
    if (cmd_i.q_init || (cmd_i.q_fin && pass_q == 2'd0)) begin
      if (cmd_i.q_init) begin
        pos_q <= PosW'((PosW'(r_q) > sz) ? sz : PosW'(r_q));
        k_q <= r_q;
        res_q <= '0;
      end else begin
        pos_q <= PosW'((PosW'(l_q - 11'd1) > sz) ? sz : PosW'(l_q - 11'd1));
        k_q <= l_q - 11'd1;
      end
      bacc_q <= '0;
      cacc_q <= '0;
    end
    if (cmd_i.q_acc) begin
      bacc_q <= bacc_q + drd_q;
      cacc_q <= cacc_q + wrd_q;
      pos_q <= pos_q - low;
    end
    if (cmd_i.q_mul) kb_q <= AccW'(k_q) * bacc_q;
    if (cmd_i.q_fin) begin
      pass_q <= pass_q + 2'd1;
      if (pass_q == 2'd0) res_q <= kb_q - cacc_q;
      else res_q <= res_q - (kb_q - cacc_q);
    end
    if (cmd_i.out_load) begin
      obad_q <= bad_q;
      if (bad_q) sum_q <= '0;
      else sum_q <= res_q - (kb_q - cacc_q);
    end
  end

  assign sum_o = sum_q;
  assign bad_o = obad_q;
endmodule

>>> sv/range_add_range_sum_fenwick.sv
// top level of the range add / range sum block on two fenwick trees
// query: two prefix walks, one memory port per tree
// throughput: one request at a time, set by the serial node walk
// reset: asynchronous active low; a clearing pass over all MAX_ELEMENTS+1 entries zeroes the trees
// before the first request is taken; size register resets to 1024 (or the maximum)
module range_add_range_sum_fenwick #(
  parameter int unsigned MaxElements = rars_pkg::MaxElementsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  rars_req_if.sink   req_i,
  rars_rsp_if.source rsp_o,
  rars_cfg_if.sink   cfg_i
);
  import rars_pkg::*;

  localparam int unsigned SizeRst = (MaxElements < 1024) ? MaxElements : 1024;

  logic [10:0] size_q;
  logic        clr_done;
  logic        req_rdy;
  cmd_t        cmd;
  stat_t       stat;

  // size register, saturates at MaxElements
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 11'(SizeRst);
    end else if (cfg_i.valid) begin
      size_q <= (32'(cfg_i.size_in_use) > MaxElements) ? 11'(MaxElements) :
                cfg_i.size_in_use;
    end
  end
  assign cfg_i.ready = 1'b1;

  // requests held off until the clearing pass is done
  assign req_i.ready = req_rdy && clr_done;

  rars_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid && clr_done),
    .req_ready_o (req_rdy),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rars_dp #(.MaxElements(MaxElements)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_busy_i (1'b1),
    .clr_done_o (clr_done),
    .size_i     (size_q),
    .req_type_i (req_i.req_type),
    .left_i     (req_i.left_index),
    .right_i    (req_i.right_index),
    .value_i    (req_i.add_value),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .sum_o      (rsp_o.range_sum),
    .bad_o      (rsp_o.bad_range)
  );

  // no request taken while a response is pending
  a_no_req_with_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready) else $error("request taken during response");
  // no request before clearing done
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_done |-> !req_i.ready) else $error("request before clear");
  // a bad range always reports zero
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.bad_range) |-> (rsp_o.range_sum == '0)) else $error("bad nonzero");
endmodule

>>> bench/range_add_range_sum_fenwick_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the range add / range sum fenwick block
module range_add_range_sum_fenwick_tb;
  import rars_pkg::*;

  localparam int unsigned MaxEl = 1024;
  localparam longint unsigned CycleLimit = 1500000;

  // expected result of a query or of a rejected request
  typedef struct {
    logic signed [63:0] sum;
    logic               bad;
  } sum_result_t;

  // model of the two trees, kept as fenwick arrays
  class range_sum_scoreboard;
    logic [63:0] diffs[MaxEl + 1];
    logic [63:0] wdiffs[MaxEl + 1];
    logic [10:0] size_q;
    sum_result_t pending[$];
    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_bad;

    function new();
      foreach (diffs[i]) begin
        diffs[i] = '0;
        wdiffs[i] = '0;
      end
      size_q = 11'd1024;
      errors = 0;
      n_checked = 0;
      n_bad = 0;
    endfunction

    function void set_size(logic [10:0] v);
      size_q = (v > MaxEl) ? 11'(MaxEl) : v;
    endfunction

    function void tree_bump(bit weighted, int unsigned pos, logic [63:0] v);
      while (pos >= 1 && pos <= size_q) begin
        if (weighted) wdiffs[pos] += v;
        else diffs[pos] += v;
        pos += pos & (~pos + 1);
      end
    endfunction

    function logic [63:0] tree_prefix(bit weighted, int unsigned pos);
      logic [63:0] acc;
      acc = '0;
      if (pos > size_q) pos = size_q;
      while (pos != 0) begin
        acc += weighted ? wdiffs[pos] : diffs[pos];
        pos -= pos & (~pos + 1);
      end
      return acc;
    endfunction

    function logic [63:0] elem_prefix(int unsigned k);
      return 64'(k) * tree_prefix(0, k) - tree_prefix(1, k);
    endfunction

    // note one accepted request
    function void note_request(req_type_e kind, logic [10:0] l, logic [10:0] r,
                               logic signed [31:0] v);
      logic [63:0] wv;
      sum_result_t res;
      wv = 64'(v);
      if (l < 1 || l > r || r > size_q) begin
        res.sum = '0;
        res.bad = 1'b1;
        pending.push_back(res);
      end else if (kind == REQ_ADD) begin
        tree_bump(0, l, wv);
        tree_bump(0, r + 1, -wv);
        tree_bump(1, l, wv * 64'(l - 1));
        tree_bump(1, r + 1, -(wv * 64'(r)));
      end else begin
        res.sum = elem_prefix(r) - elem_prefix(l - 1);
        res.bad = 1'b0;
        pending.push_back(res);
      end
    endfunction

    function void check_result(logic signed [63:0] sum, logic bad);
      sum_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result range_sum=%0d bad_range=%0b", sum, bad);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (bad) n_bad++;
      if (sum !== e.sum) begin
        $error("range_sum expected %0d actual %0d", e.sum, sum);
        errors++;
      end
      if (bad !== e.bad) begin
        $error("bad_range expected %0b actual %0b", e.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  rars_req_if req_ch ();
  rars_rsp_if rsp_ch ();
  rars_cfg_if cfg_ch ();

  range_add_range_sum_fenwick dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  range_sum_scoreboard sb;
  longint unsigned cycles;
  bit calm;          // last part of the run: no idling on either side
  bit long_hold;     // receiver held off for a long stretch
  int unsigned n_sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // timeout watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // response side: random ready bursts, plus one long hold-off
  initial begin
    int unsigned n;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        rsp_ch.ready = 1'b0;
        repeat (3000) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready = 1'b0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        rsp_ch.ready = 1'b1;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  // check each accepted result at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.range_sum, rsp_ch.bad_range);
  end

  // one request, waits for its handshake; random gap beforehand at times, never when calm
  task automatic send_request(req_type_e kind, logic [10:0] l, logic [10:0] r,
                              logic signed [31:0] v);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = kind;
    req_ch.left_index = l;
    req_ch.right_index = r;
    req_ch.add_value = v;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(kind, l, r, v);
    n_sent++;
    @(negedge clk_i);
    req_ch.valid = 1'b0;
  endtask

  // wait until every expected result has arrived, then let an add drain
  task automatic drain_block();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_size(logic [10:0] v);
    drain_block();
    cfg_ch.valid = 1'b1;
    cfg_ch.size_in_use = v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_size(v);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // random request biased to valid ranges within the current size
  task automatic random_request(int unsigned span_max);
    logic [10:0] l, r, sz;
    req_type_e kind;
    logic signed [31:0] v;
    sz = sb.size_q;
    kind = req_type_e'($urandom_range(0, 1));
    v = $urandom;
    if ($urandom_range(0, 3) == 0) v = $signed(32'($urandom_range(0, 200))) - 100;
    if ($urandom_range(0, 9) == 0 || sz == 0) begin
      // noise: any field values at all
      l = 11'($urandom);
      r = 11'($urandom);
    end else begin
      l = 11'($urandom_range(1, sz));
      r = 11'($urandom_range(l, (l + span_max > sz) ? sz : l + span_max));
      if ($urandom_range(0, 7) == 0) r = sz;
      if ($urandom_range(0, 7) == 0) l = 1;
      if (l > r) r = l;
    end
    send_request(kind, l, r, v);
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    long_hold = 1'b0;
    n_sent = 0;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ADD;
    req_ch.left_index = '0;
    req_ch.right_index = '0;
    req_ch.add_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.size_in_use = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes of the fields and each error case at reset size
    send_request(REQ_QUERY, 11'd1, 11'd1024, 32'sd0);
    send_request(REQ_ADD, 11'd1, 11'd1024, 32'h7fffffff);
    send_request(REQ_ADD, 11'd1, 11'd1, 32'h80000000);
    send_request(REQ_ADD, 11'd1024, 11'd1024, -32'sd1);
    send_request(REQ_ADD, 11'd512, 11'd700, 32'sd12345);
    send_request(REQ_QUERY, 11'd1, 11'd1024, 32'sd0);
    send_request(REQ_QUERY, 11'd1024, 11'd1024, 32'hffffffff);
    send_request(REQ_QUERY, 11'd600, 11'd650, 32'sd0);
    send_request(REQ_ADD, 11'd0, 11'd5, 32'sd7);          // left of zero
    send_request(REQ_QUERY, 11'd0, 11'd0, 32'sd0);
    send_request(REQ_ADD, 11'd9, 11'd3, 32'sd7);          // left above right
    send_request(REQ_QUERY, 11'd1025, 11'd2047, 32'sd0);  // beyond the size
    send_request(REQ_ADD, 11'd2047, 11'd2047, 32'sd1);
    send_request(REQ_QUERY, 11'd1, 11'd1023, 32'sd0);

    // size above the maximum saturates, and zero makes everything invalid
    write_size(11'd2047);
    send_request(REQ_QUERY, 11'd1, 11'd1024, 32'sd0);
    write_size(11'd0);
    send_request(REQ_QUERY, 11'd1, 11'd1, 32'sd0);
    send_request(REQ_ADD, 11'd1, 11'd1, 32'sd3);
    // shrink after adds; the trees are kept, growing back shows stale nodes
    write_size(11'd1);
    send_request(REQ_ADD, 11'd1, 11'd1, 32'sd100);
    send_request(REQ_QUERY, 11'd1, 11'd1, 32'sd0);
    send_request(REQ_QUERY, 11'd1, 11'd2, 32'sd0);
    write_size(11'd37);
    send_request(REQ_ADD, 11'd5, 11'd37, -32'sd9);
    send_request(REQ_QUERY, 11'd1, 11'd37, 32'sd0);
    write_size(11'd1024);
    send_request(REQ_QUERY, 11'd1, 11'd1024, 32'sd0);

    // receiver holds off while requests keep coming in
    long_hold = 1'b1;
    repeat (60) random_request(64);

    // sender pauses until every result is back
    drain_block();

    // random phases across several sizes, the extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_size(11'd1024);
        1: write_size(11'd1);
        2: write_size(11'd2);
        3: write_size(11'($urandom_range(3, 100)));
        4: write_size(11'($urandom_range(101, 1023)));
        5: write_size(11'($urandom_range(0, 2047)));
        6: write_size(11'd16);
        default: begin
          write_size(11'd1024);
          calm = 1'b1;
        end
      endcase
      repeat (100) random_request(ph == 7 ? 1024 : 48);
    end

    drain_block();
    $display("sent %0d requests, checked %0d results (%0d rejected ranges)",
             n_sent, sb.n_checked, sb.n_bad);
    $display("covered sizes 0, 1, 2, 16, 1024, saturation and a long output stall");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
sv/rars_pkg.sv
sv/rars_if.sv
sv/rars_ctrl.sv
sv/rars_dp.sv
sv/range_add_range_sum_fenwick.sv
bench/range_add_range_sum_fenwick_tb.sv
